// ===== hw/rtl/lfps_pkg.sv =====
// lfps_pkg: shared types, constants and the microcode table for the
// line-follow PID steering block. No dependencies.
`timescale 1ns / 1ps

package lfps_pkg;

    localparam int ERR_W     = 16;
    localparam int INTEG_W   = 22;
    localparam int DERIV_W   = ERR_W + 1;
    localparam int GAIN_W    = 16;
    localparam int SPD_W     = 16;
    localparam int DUTY_W    = 16;
    localparam int MUL_A_W   = 17;
    localparam int MUL_B_W   = INTEG_W + 1;
    localparam int ACC_W     = MUL_A_W + MUL_B_W;
    localparam int CORR_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int STEP_W    = 3;

    localparam logic signed [INTEG_W-1:0] INTEG_LIM = 22'sd1638400;
    localparam logic signed [CORR_W-1:0]  CORR_LIM  = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_BASE_SPEED  = 3'd3,
        REG_SPEED_LIMIT = 3'd4,
        REG_PWM_TOP     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [SPD_W-1:0]  base_speed;
        logic [SPD_W-1:0]  speed_limit;
        logic [SPD_W-1:0]  pwm_top;
    } t_cfg;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [2:0] {
        MA_GAIN_P,
        MA_GAIN_I,
        MA_GAIN_D,
        MA_SPEED_L,
        MA_SPEED_R
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_ERR,
        MB_INTEG,
        MB_DERIV,
        MB_PWM
    } t_mul_b;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_RUN,
        EM_STOP
    } t_emit;

    typedef enum logic {
        JC_NONE,
        JC_LOST
    } t_jcond;

    // one control word
    typedef struct packed {
        t_mul_a  a_sel;
        t_mul_b  b_sel;
        t_acc_op acc_op;
        logic    upd_pre;    // integral clamp and derivative into temporaries
        logic    set_speed;  // correction -> wheel speeds, commit state
        logic    set_duty_l; // left duty from product
        t_emit   emit;       // last step: write result register
        t_jcond  jcond;
        t_step   jtarget;
    } t_uop;

    // sequencer -> datapath
    typedef struct packed {
        logic start; // input item taken this cycle
        logic run;   // current control word executes this cycle
        t_uop uop;
    } t_ctrl;

    localparam t_step STEP_STOP = 3'd6;

    // program: PID products accumulate, then speeds, two duties; lost -> stop
    function automatic t_uop ucode(input t_step s);
        t_uop u;
        u = '{a_sel: MA_GAIN_P, b_sel: MB_ERR, acc_op: ACC_NONE, upd_pre: 1'b0,
              set_speed: 1'b0, set_duty_l: 1'b0, emit: EM_NONE, jcond: JC_NONE,
              jtarget: '0};
        case (s)
            3'd0: begin
                u.jcond   = JC_LOST;
                u.jtarget = STEP_STOP;
                u.upd_pre = 1'b1;
                u.a_sel   = MA_GAIN_P;
                u.b_sel   = MB_ERR;
                u.acc_op  = ACC_LOAD;
            end
            3'd1: begin
                u.a_sel  = MA_GAIN_I;
                u.b_sel  = MB_INTEG;
                u.acc_op = ACC_ADD;
            end
            3'd2: begin
                u.a_sel  = MA_GAIN_D;
                u.b_sel  = MB_DERIV;
                u.acc_op = ACC_ADD;
            end
            3'd3: begin
                u.set_speed = 1'b1;
            end
            3'd4: begin
                u.a_sel      = MA_SPEED_L;
                u.b_sel      = MB_PWM;
                u.set_duty_l = 1'b1;
            end
            3'd5: begin
                u.a_sel = MA_SPEED_R;
                u.b_sel = MB_PWM;
                u.emit  = EM_RUN;
            end
            3'd6: begin
                u.emit = EM_STOP;
            end
            default: begin
                u.emit = EM_STOP;
            end
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/lfps_ifs.sv =====
// lfps_ifs: valid/ready channel interfaces for the line-follow PID
// steering block (sensor items, duty items, register writes). Uses lfps_pkg.
`timescale 1ns / 1ps

interface lfps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 on_line;
    logic signed [lfps_pkg::ERR_W-1:0]    line_error;

    modport source (output valid, on_line, line_error, input ready);
    modport sink   (input valid, on_line, line_error, output ready);
endinterface

interface lfps_out_if;
    logic                          valid;
    logic                          ready;
    logic [lfps_pkg::DUTY_W-1:0]   left_duty;
    logic [lfps_pkg::DUTY_W-1:0]   right_duty;
    logic                          motors_stopped;

    modport source (output valid, left_duty, right_duty, motors_stopped, input ready);
    modport sink   (input valid, left_duty, right_duty, motors_stopped, output ready);
endinterface

interface lfps_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lfps_pkg::CFG_IDX_W-1:0]   index;
    logic [lfps_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lfps_cfg.sv =====
// lfps_cfg: register file for gains, speeds and PWM top.
// Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [lfps_pkg::CFG_IDX_W-1:0] i_wr_idx,
    input  logic [lfps_pkg::CFG_DAT_W-1:0] i_wr_data,
    output lfps_pkg::t_cfg                 o_cfg
);
    import lfps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= 16'd256;
            r_cfg.gain_i      <= 16'd0;
            r_cfg.gain_d      <= 16'd0;
            r_cfg.base_speed  <= 16'd16384;
            r_cfg.speed_limit <= 16'd32768;
            r_cfg.pwm_top     <= 16'd6249;
        end else if (i_wr_en) begin
            case (t_reg_idx'(i_wr_idx))
                REG_GAIN_P:      r_cfg.gain_p      <= i_wr_data;
                REG_GAIN_I:      r_cfg.gain_i      <= i_wr_data;
                REG_GAIN_D:      r_cfg.gain_d      <= i_wr_data;
                REG_BASE_SPEED:  r_cfg.base_speed  <= i_wr_data;
                REG_SPEED_LIMIT: r_cfg.speed_limit <= i_wr_data;
                REG_PWM_TOP:     r_cfg.pwm_top     <= i_wr_data;
                default: ; // unknown index: dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/lfps_seq.sv =====
// lfps_seq: microcode sequencer - step counter, control ROM lookup,
// lost-line jump, input/output handshakes. Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_on_line,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lfps_pkg::t_ctrl o_ctrl
);
    import lfps_pkg::*;

    logic  r_busy;
    logic  r_lost;
    t_step r_step;
    logic  r_out_valid;

    t_uop  uop;
    logic  start;
    logic  stall;
    logic  run;
    logic  emit_fire;
    t_step n_step;

    assign uop       = ucode(r_step);
    assign start     = i_in_valid && !r_busy;
    // last step holds while the result register is still occupied
    assign stall     = (uop.emit != EM_NONE) && r_out_valid && !i_out_ready;
    assign run       = r_busy && !stall;
    assign emit_fire = run && (uop.emit != EM_NONE);

    always_comb begin
        if (uop.jcond == JC_LOST && r_lost) begin
            n_step = uop.jtarget;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_lost      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (start) begin
                r_busy <= 1'b1;
                r_lost <= !i_in_on_line;
                r_step <= '0;
            end else if (emit_fire) begin
                r_busy <= 1'b0;
            end else if (run) begin
                r_step <= n_step;
            end

            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready   = !r_busy;
    assign o_out_valid  = r_out_valid;
    assign o_ctrl.start = start;
    assign o_ctrl.run   = run;
    assign o_ctrl.uop   = uop;

endmodule

// ===== hw/rtl/lfps_dp.sv =====
// lfps_dp: PID datapath - shared multiplier, accumulator, clamps, state
// and result registers, driven by control words. Depends on lfps_pkg.
`timescale 1ns / 1ps

module lfps_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lfps_pkg::t_ctrl                    i_ctrl,
    input  lfps_pkg::t_cfg                     i_cfg,
    input  logic signed [lfps_pkg::ERR_W-1:0]  i_line_error,
    output logic [lfps_pkg::DUTY_W-1:0]        o_left_duty,
    output logic [lfps_pkg::DUTY_W-1:0]        o_right_duty,
    output logic                               o_motors_stopped
);
    import lfps_pkg::*;

    // loop state
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev;
    // per-item working registers
    logic signed [ERR_W-1:0]   r_err;
    logic signed [INTEG_W-1:0] r_integ_new;
    logic signed [DERIV_W-1:0] r_deriv;
    logic signed [ACC_W-1:0]   r_acc;
    logic [SPD_W-1:0]          r_speed_l;
    logic [SPD_W-1:0]          r_speed_r;
    logic [DUTY_W-1:0]         r_duty_l;
    logic [DUTY_W-1:0]         r_out_l;
    logic [DUTY_W-1:0]         r_out_r;
    logic                      r_out_stop;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   prod;
    logic [DUTY_W-1:0]         duty;
    logic signed [INTEG_W:0]   isum;
    logic signed [INTEG_W-1:0] integ_clamped;
    logic signed [ACC_W-8:0]   corr_full;
    logic signed [CORR_W-1:0]  corr;
    logic signed [SPD_W+1:0]   left_raw;
    logic signed [SPD_W+1:0]   right_raw;
    logic signed [SPD_W+1:0]   limit_s;
    logic [SPD_W-1:0]          left_spd;
    logic [SPD_W-1:0]          right_spd;

    always_comb begin
        case (i_ctrl.uop.a_sel)
            MA_GAIN_P:  mul_a = MUL_A_W'($signed(i_cfg.gain_p));
            MA_GAIN_I:  mul_a = MUL_A_W'($signed(i_cfg.gain_i));
            MA_GAIN_D:  mul_a = MUL_A_W'($signed(i_cfg.gain_d));
            MA_SPEED_L: mul_a = $signed({1'b0, r_speed_l});
            MA_SPEED_R: mul_a = $signed({1'b0, r_speed_r});
            default:    mul_a = '0;
        endcase
        case (i_ctrl.uop.b_sel)
            MB_ERR:   mul_b = MUL_B_W'(r_err);
            MB_INTEG: mul_b = MUL_B_W'(r_integ_new);
            MB_DERIV: mul_b = MUL_B_W'(r_deriv);
            MB_PWM:   mul_b = $signed({{(MUL_B_W-SPD_W){1'b0}}, i_cfg.pwm_top});
            default:  mul_b = '0;
        endcase
    end

    // 17x23 signed product, operands sign-extended to the product width
    assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

    // (speed * top) >> 15, saturated to 16 bits
    assign duty = (prod[ACC_W-1:DUTY_W+15] != '0) ? '1 : prod[DUTY_W+14:15];

    // integral update with clamp
    always_comb begin
        isum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(r_err);
        if (isum > (INTEG_W+1)'(INTEG_LIM)) begin
            integ_clamped = INTEG_LIM;
        end else if (isum < -(INTEG_W+1)'(INTEG_LIM)) begin
            integ_clamped = -INTEG_LIM;
        end else begin
            integ_clamped = isum[INTEG_W-1:0];
        end
    end

    // floor(sum / 128), clamp, then wheel speeds
    always_comb begin
        corr_full = r_acc[ACC_W-1:7];
        if (corr_full > (ACC_W-7)'(CORR_LIM)) begin
            corr = CORR_LIM;
        end else if (corr_full < -(ACC_W-7)'(CORR_LIM)) begin
            corr = -CORR_LIM;
        end else begin
            corr = corr_full[CORR_W-1:0];
        end
        limit_s   = $signed({2'b00, i_cfg.speed_limit});
        left_raw  = $signed({2'b00, i_cfg.base_speed}) - (SPD_W+2)'(corr);
        right_raw = $signed({2'b00, i_cfg.base_speed}) + (SPD_W+2)'(corr);
        if (left_raw[SPD_W+1]) begin
            left_spd = '0;
        end else if (left_raw > limit_s) begin
            left_spd = i_cfg.speed_limit;
        end else begin
            left_spd = left_raw[SPD_W-1:0];
        end
        if (right_raw[SPD_W+1]) begin
            right_spd = '0;
        end else if (right_raw > limit_s) begin
            right_spd = i_cfg.speed_limit;
        end else begin
            right_spd = right_raw[SPD_W-1:0];
        end
    end

    // loop state: reset to zero, written once per on-line item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_ctrl.run && i_ctrl.uop.set_speed) begin
            r_integ <= r_integ_new;
            r_prev  <= r_err;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_err <= i_line_error;
        end
        if (i_ctrl.run) begin
            if (i_ctrl.uop.upd_pre) begin
                r_integ_new <= integ_clamped;
                r_deriv     <= DERIV_W'(r_err) - DERIV_W'(r_prev);
            end
            case (i_ctrl.uop.acc_op)
                ACC_LOAD: r_acc <= prod;
                ACC_ADD:  r_acc <= r_acc + prod;
                default:  ;
            endcase
            if (i_ctrl.uop.set_speed) begin
                r_speed_l <= left_spd;
                r_speed_r <= right_spd;
            end
            if (i_ctrl.uop.set_duty_l) begin
                r_duty_l <= duty;
            end
            case (i_ctrl.uop.emit)
                EM_RUN: begin
                    r_out_l    <= r_duty_l;
                    r_out_r    <= duty;
                    r_out_stop <= 1'b0;
                end
                EM_STOP: begin
                    r_out_l    <= '0;
                    r_out_r    <= '0;
                    r_out_stop <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_left_duty      = r_out_l;
    assign o_right_duty     = r_out_r;
    assign o_motors_stopped = r_out_stop;

endmodule

// ===== hw/rtl/line_follow_pid_steering.sv =====
// line_follow_pid_steering: top level of the line-follow PID steering block.
// Depends on lfps_pkg, lfps_ifs, lfps_cfg, lfps_seq, lfps_dp.
//
// Usage
//   i_in  : one sensor item per reading (on_line flag, Q2.14 line_error).
//   o_out : one duty item per sensor item (left_duty, right_duty,
//           motors_stopped), in input order.
//   i_cfg : register writes (index 0..5: gain_p, gain_i, gain_d, base_speed,
//           speed_limit, pwm_top); always ready, unknown indexes dropped.
//           Write only while no item is in flight.
// Timing
//   An on-line item runs the 6-step microprogram: P, I, D products into the
//   accumulator, clamp to wheel speeds, then left and right duty products,
//   all on one shared 17x23 multiplier; the last step loads the result
//   register. A lost-line item jumps straight to the stop step instead.
//   Next item is taken the cycle after the result is loaded, so it can
//   overlap a result still waiting on o_out.
// Reset: synchronous, active low; registers back to defaults, integral and
//   previous error cleared, no item in flight, o_out.valid low.
// Back-pressure: a stalled o_out holds the result; the next item then waits
//   in its final step and i_in.ready stays low until the register frees up.
`timescale 1ns / 1ps

module line_follow_pid_steering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfps_in_if.sink     i_in,
    lfps_out_if.source  o_out,
    lfps_cfg_if.sink    i_cfg
);
    import lfps_pkg::*;

    t_cfg  cfg;
    t_ctrl ctrl;

    // register port never back-pressures
    assign i_cfg.ready = 1'b1;

    lfps_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_cfg     (cfg)
    );

    // step counter + control ROM
    lfps_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_on_line (i_in.on_line),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_ctrl       (ctrl)
    );

    // multiplier, accumulator, clamps, loop state, result register
    lfps_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_cfg            (cfg),
        .i_line_error     (i_in.line_error),
        .o_left_duty      (o_out.left_duty),
        .o_right_duty     (o_out.right_duty),
        .o_motors_stopped (o_out.motors_stopped)
    );

endmodule
